// ===== hw/rtl/lfcf_pkg.sv =====
// Shared types and constants for the letter/digit command framer.
package lfcf_pkg;

  // Bytes in one frame: one command byte and the rest decimal digits.
  localparam int FRAME_BYTES_DEF = 6;
  // Entries in the queue between framer and decoder.
  localparam int QUEUE_DEPTH = 2;

  localparam int VALUE_W = 17;
  localparam int DIGIT_W = 4;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [7:0] CMD_RESET    = 8'h4B; // K
  localparam logic [7:0] CMD_SPEED    = 8'h53; // S
  localparam logic [7:0] CMD_RESOL    = 8'h52; // R
  localparam logic [7:0] CMD_PLUS     = 8'h2B; // +
  localparam logic [7:0] CMD_MINUS    = 8'h2D; // -
  localparam logic [7:0] CMD_LIGHT    = 8'h41; // A
  localparam logic [7:0] CMD_INFRARED = 8'h4C; // L
  localparam logic [7:0] CMD_GATHER   = 8'h47; // G
  localparam logic [7:0] CMD_DEBUG    = 8'h4A; // J
  localparam logic [7:0] CMD_DISTANCE = 8'h50; // P
  localparam logic [7:0] CMD_QM       = 8'h4D; // M, also sleep count
  localparam logic [7:0] CMD_QN       = 8'h4E; // N, also sleep wake
  localparam logic [7:0] CMD_QB       = 8'h42;
  localparam logic [7:0] CMD_QC       = 8'h43;
  localparam logic [7:0] CMD_QD       = 8'h44;
  localparam logic [7:0] CMD_QE       = 8'h45;
  localparam logic [7:0] CMD_QF       = 8'h46;
  localparam logic [7:0] CMD_QH       = 8'h48;
  localparam logic [7:0] CMD_QI       = 8'h49;
  localparam logic [7:0] CMD_QQ       = 8'h51;
  localparam logic [7:0] CMD_STREAM   = 8'h4F; // O

  localparam logic [3:0] ACT_RESET      = 4'd0;
  localparam logic [3:0] ACT_SPEED      = 4'd1;
  localparam logic [3:0] ACT_RESOLUTION = 4'd2;
  localparam logic [3:0] ACT_LIMIT      = 4'd3;
  localparam logic [3:0] ACT_LIGHT      = 4'd4;
  localparam logic [3:0] ACT_INFRARED   = 4'd5;
  localparam logic [3:0] ACT_GATHER     = 4'd6;
  localparam logic [3:0] ACT_DEBUG      = 4'd7;
  localparam logic [3:0] ACT_DISTANCE   = 4'd8;
  localparam logic [3:0] ACT_QUERY      = 4'd9;
  localparam logic [3:0] ACT_STREAM     = 4'd10;
  localparam logic [3:0] ACT_NONE       = 4'd11;

  localparam logic signed [4:0] SLEEP_MAX  = 5'sd15;
  localparam logic signed [4:0] SLEEP_WAKE = -5'sd1;
  localparam logic signed [4:0] SLEEP_ONE  = 5'sd1;

  // One completed frame handed from framer to decoder.
  typedef struct packed {
    logic [7:0]         cmd;
    logic [VALUE_W-1:0] value;
    logic [DIGIT_W-1:0] digit;
    logic               port;
  } frame_t;

endpackage

// ===== hw/rtl/lfcf_front.sv =====
// Per-port framers: collect command byte and digits, emit completed frames.
module lfcf_front
  import lfcf_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_port,
  output logic       push,
  output frame_t     push_frame,
  input  logic       queue_ready
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [CNT_W-1:0]   cnt_r [2];
  logic [7:0]         cmd_r [2];
  logic [VALUE_W-1:0] val_r [2];

  logic               accept;
  logic               is_digit;
  logic               start;
  logic [DIGIT_W-1:0] digit;
  logic [CNT_W-1:0]   cur_cnt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [VALUE_W-1:0] val_nxt;
  logic               done;

  assign in_ready = queue_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cur_cnt  = cnt_r[in_port];
    is_digit = (in_rx_byte >= CHAR_ZERO) && (in_rx_byte <= CHAR_NINE);
    digit    = DIGIT_W'(in_rx_byte - CHAR_ZERO);
    // first byte of a frame, or a non-digit restarts with this byte as command
    start    = (cur_cnt == '0) || !is_digit;
    cnt_nxt  = start ? CNT_W'(1) : cur_cnt + CNT_W'(1);
    val_nxt  = start ? '0
                     : (val_r[in_port] << 3) + (val_r[in_port] << 1)
                       + VALUE_W'(digit);
    done     = (cnt_nxt == CNT_W'(FRAME_BYTES));
  end

  assign push             = accept && done;
  assign push_frame.cmd   = cmd_r[in_port];
  assign push_frame.value = val_nxt;
  assign push_frame.digit = digit;
  assign push_frame.port  = in_port;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else if (accept) begin
      cnt_r[in_port] <= done ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (start) begin
        cmd_r[in_port] <= in_rx_byte;
      end
      val_r[in_port] <= val_nxt;
    end
  end

endmodule

// ===== hw/rtl/lfcf_queue.sv =====
// Short frame queue between framer and decoder.
module lfcf_queue
  import lfcf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_frame,
  output logic   push_ready,
  output logic   pop_valid,
  output frame_t pop_frame,
  input  logic   pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_frame  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (pop) begin
        rd_r <= ptr_inc(rd_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_frame;
    end
  end

endmodule

// ===== hw/rtl/lfcf_back.sv =====
// Frame decoder, shared sleep counter and result register.
module lfcf_back
  import lfcf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  frame_t             pop_frame,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_action,
  output logic signed [17:0] out_value,
  output logic [3:0]         out_query_kind,
  output logic signed [4:0]  out_sleep_level,
  output logic               out_from_port
);

  logic                valid_r;
  logic signed [4:0]   sleep_r;
  logic signed [4:0]   sleep_nxt;
  logic [3:0]          act_nxt;
  logic signed [17:0]  val_nxt;
  logic [3:0]          qk_nxt;
  logic signed [17:0]  sval;

  logic [3:0]          act_r;
  logic signed [17:0]  val_r;
  logic [3:0]          qk_r;
  logic signed [4:0]   lvl_r;
  logic                port_r;

  // take a frame whenever the result slot is empty or being drained
  assign pop = pop_valid && (!valid_r || out_ready);

  always_comb begin
    sleep_nxt = sleep_r;
    if (pop_frame.cmd != CMD_QM && sleep_r == SLEEP_ONE) begin
      sleep_nxt = '0;
    end
    if (pop_frame.cmd == CMD_QM) begin
      if (sleep_r < SLEEP_MAX) begin
        sleep_nxt = sleep_r + 5'sd1;
      end
    end else if (pop_frame.cmd == CMD_QN) begin
      sleep_nxt = SLEEP_WAKE;
    end
  end

  always_comb begin
    sval    = signed'({1'b0, pop_frame.value});
    act_nxt = ACT_NONE;
    val_nxt = '0;
    qk_nxt  = '0;
    unique case (pop_frame.cmd)
      CMD_RESET:    act_nxt = ACT_RESET;
      CMD_SPEED:    begin act_nxt = ACT_SPEED;      val_nxt = sval;  end
      CMD_RESOL:    begin act_nxt = ACT_RESOLUTION; val_nxt = sval;  end
      CMD_PLUS:     begin act_nxt = ACT_LIMIT;      val_nxt = sval;  end
      CMD_MINUS:    begin act_nxt = ACT_LIMIT;      val_nxt = -sval; end
      CMD_LIGHT:    begin act_nxt = ACT_LIGHT;      val_nxt = sval;  end
      CMD_INFRARED: begin
        act_nxt = ACT_INFRARED;
        // digit 0 turns off, 1 turns on, anything else keeps
        if (pop_frame.digit == 4'd0) begin
          val_nxt = 18'sd1;
        end else if (pop_frame.digit == 4'd1) begin
          val_nxt = 18'sd2;
        end
      end
      CMD_GATHER:   begin act_nxt = ACT_GATHER;     val_nxt = sval;  end
      CMD_DEBUG:    act_nxt = ACT_DEBUG;
      CMD_DISTANCE: begin act_nxt = ACT_DISTANCE;   val_nxt = sval;  end
      CMD_QM:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd0; end
      CMD_QN:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd1; end
      CMD_QB:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd2; end
      CMD_QC:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd3; end
      CMD_QD:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd4; end
      CMD_QE:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd5; end
      CMD_QF:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd6; end
      CMD_QH:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd7; end
      CMD_QI:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd8; end
      CMD_QQ:       begin act_nxt = ACT_QUERY; qk_nxt = 4'd9; end
      CMD_STREAM:   begin
        // stream is honored on the second port only
        if (pop_frame.port) begin
          act_nxt = ACT_STREAM;
        end
      end
      default:      act_nxt = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sleep_r <= '0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        sleep_r <= sleep_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      act_r  <= act_nxt;
      val_r  <= val_nxt;
      qk_r   <= qk_nxt;
      lvl_r  <= sleep_nxt;
      port_r <= pop_frame.port;
    end
  end

  assign out_valid       = valid_r;
  assign out_action      = act_r;
  assign out_value       = val_r;
  assign out_query_kind  = qk_r;
  assign out_sleep_level = lvl_r;
  assign out_from_port   = port_r;

endmodule

// ===== hw/rtl/letter_digit_command_framer.sv =====
// Top level of the two-port letter/digit command framer.
//
// Input channel (in_valid/in_ready): one received serial byte per beat,
// in_rx_byte, tagged with its source port in_port. Each port frames one
// command byte followed by FRAME_BYTES-1 decimal digits; a non-digit after
// the command byte restarts that port's frame with the byte as new command.
// Result channel (out_valid/out_ready): one beat per completed frame with
// the decoded action, signed value, query kind, shared sleep level and port.
// Throughput: one input beat per cycle while the queue has room. A completing
// byte is written into the two-entry frame queue in its accept cycle; the
// decoder takes it from the queue once the result slot is empty or being
// drained, and registers the result. The sleep counter is updated by the
// decoder when it takes a frame.
// When the receiver stalls, the result register holds, the queue fills, and
// in_ready drops once the queue is full; bytes are never dropped.
// Reset (rst_n low, synchronous) empties both framers, the queue and the
// result register, and clears the sleep counter to zero.
module letter_digit_command_framer
  import lfcf_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_port,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_action,
  output logic signed [17:0] out_value,
  output logic [3:0]         out_query_kind,
  output logic signed [4:0]  out_sleep_level,
  output logic               out_from_port
);

  logic   push;
  frame_t push_frame;
  logic   queue_ready;
  logic   pop_valid;
  frame_t pop_frame;
  logic   pop;

  lfcf_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .in_port     (in_port),
    .push        (push),
    .push_frame  (push_frame),
    .queue_ready (queue_ready)
  );

  lfcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .push_ready (queue_ready),
    .pop_valid  (pop_valid),
    .pop_frame  (pop_frame),
    .pop        (pop)
  );

  lfcf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_frame       (pop_frame),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_action      (out_action),
    .out_value       (out_value),
    .out_query_kind  (out_query_kind),
    .out_sleep_level (out_sleep_level),
    .out_from_port   (out_from_port)
  );

endmodule
